@@ rtl/mpr_pkg.sv @@
// Shared types, codes and default sizes of the midpoint parabola rasteriser.
package mpr_pkg;

	localparam int unsigned COORD_BITS_DEF    = 10;
	localparam int unsigned DECISION_BITS_DEF = 48;

	// Bit positions inside the result tuser.
	localparam int unsigned USER_MARKER = 0;
	localparam int unsigned USER_STATUS = 1;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [4:0] {
		CS_IDLE,
		CS_FLAT,
		CS_STEEP,
		CS_MARK,
		CS_SQX,
		CS_DIV1,
		CS_DIV1W,
		CS_SQT,
		CS_TXY,
		CS_NUM,
		CS_DIV2,
		CS_DIV2W,
		CS_W1,
		CS_W2,
		CS_SD,
		CS_SD2,
		CS_SM
	} ctl_state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_SQX,
		MUL_SQT,
		MUL_TXY,
		MUL_NUM,
		MUL_W1,
		MUL_W2,
		MUL_SD,
		MUL_SM
	} mul_op_t;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_TURN_X,
		DIV_TURN_Y
	} div_op_t;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_IDLE,
		STEP_FLAT,
		STEP_STEEP,
		STEP_MARK
	} step_kind_t;

	typedef struct packed {
		logic       ld_target;
		mul_op_t    mul_op;
		div_op_t    div_op;
		logic       ld_dx2;
		logic       ld_turn_x;
		logic       ld_t2;
		logic       ld_turn_y;
		logic       ld_ew2;
		logic       ld_sdec;
		logic       ld_smove;
		logic       init_flat;
		step_kind_t step_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic coord_zero;
		logic at_turn;
		logic turn_le_ty;
		logic cur_ge_ty;
		logic div_done;
	} dp_status_t;

endpackage

@@ rtl/mpr_divider.sv @@
// Restoring divider that retires one quotient bit per cycle.
module mpr_divider import mpr_pkg::*; #(
	parameter int unsigned QW = 4 * COORD_BITS_DEF,
	parameter int unsigned VW = 2 * COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [QW-1:0] quotient,
	output logic          done
);

	localparam int unsigned CNTW = $clog2(QW);
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(QW - 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   divisor_q;
	logic [QW-1:0]   dq_q;
	logic [VW:0]     trial;
	logic [VW:0]     diff;
	logic            fits;

	assign trial = {rem_q, dq_q[QW-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			dq_q      <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			dq_q  <= {dq_q[QW-2:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

@@ rtl/mpr_datapath.sv @@
// Datapath of the rasteriser: set-up multiplier, divider, decision registers and result word.
module mpr_datapath import mpr_pkg::*; #(
	parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
	parameter int unsigned DECISION_BITS = DECISION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [COORD_BITS-1:0]   end_x,
	input  logic [COORD_BITS-1:0]   end_y,
	input  dp_cmd_t                 cmd,
	output dp_status_t              st,
	output logic [2*COORD_BITS-2:0] pixel_x,
	output logic [2*COORD_BITS-2:0] pixel_y,
	output logic                    marker,
	output logic                    last,
	output logic                    status
);

	localparam int unsigned CW  = COORD_BITS;
	localparam int unsigned TW  = 2 * CW;
	localparam int unsigned PXW = 2 * CW - 1;
	localparam int unsigned AW  = 3 * CW + 1;
	localparam int unsigned BW  = 2 * CW + 1;
	localparam int unsigned PW  = 5 * CW + 2;
	localparam int unsigned QW  = 4 * CW;
	localparam int unsigned DW  = DECISION_BITS;

	logic [CW-1:0]  tx_q, ty_q;
	logic [TW-1:0]  dx2_q, turn_x_q, turn_y_q;
	logic [QW-1:0]  t2_q;
	logic [PW-1:0]  p_q;
	logic [DW-1:0]  ew2_q, sdec_q, smove_q, ssame_q;
	logic [TW-1:0]  cur_x_q, cur_y_q;
	logic [DW-1:0]  dec_q, same_q, move_q;
	logic [PXW-1:0] pixel_x_q, pixel_y_q;
	logic           marker_q, last_q, status_q;

	logic [AW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic [BW-1:0]  w;
	logic [PW-1:0]  prod;
	logic           mul_en;

	logic           div_start;
	logic [QW-1:0]  div_dividend;
	logic [TW-1:0]  div_divisor;
	logic [QW-1:0]  quotient;
	logic           div_done;

	logic [DW-1:0]  ty_d, t2_d, dx4, ty6, ty8, inc_flat, p_d;
	logic           dec_pos;

	assign w = {turn_x_q, 1'b1};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_op)
			MUL_SQX: begin
				mul_a = AW'(tx_q);
				mul_b = BW'(tx_q);
			end
			MUL_SQT: begin
				mul_a = AW'(turn_x_q);
				mul_b = BW'(turn_x_q);
			end
			MUL_TXY: begin
				mul_a = AW'(turn_x_q);
				mul_b = BW'(ty_q);
			end
			MUL_NUM: begin
				mul_a = p_q[AW-1:0];
				mul_b = BW'(turn_x_q);
			end
			MUL_W1: begin
				mul_a = AW'(ty_q);
				mul_b = w;
			end
			MUL_W2: begin
				mul_a = p_q[AW-1:0];
				mul_b = w;
			end
			MUL_SD: begin
				mul_a = AW'(dx2_q);
				mul_b = BW'(turn_y_q) + BW'(1);
			end
			MUL_SM: begin
				mul_a = AW'(ty_q);
				mul_b = BW'(turn_x_q) + BW'(1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_en = cmd.mul_op != MUL_NONE;
	assign prod   = PW'(mul_a) * PW'(mul_b);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (cmd.div_op)
			DIV_TURN_X: begin
				div_start    = 1'b1;
				div_dividend = QW'(p_q[TW-1:0]);
				div_divisor  = TW'({ty_q, 1'b0});
			end
			DIV_TURN_Y: begin
				div_start    = 1'b1;
				div_dividend = p_q[QW-1:0];
				div_divisor  = dx2_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	mpr_divider #(
		.QW(QW),
		.VW(TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	assign ty_d     = DW'(turn_y_q);
	assign t2_d     = DW'(t2_q);
	assign p_d      = DW'(p_q);
	assign dx4      = DW'(dx2_q) << 2;
	assign ty6      = (ty_d << 2) + (ty_d << 1);
	assign ty8      = DW'(ty_q) << 3;
	assign inc_flat = '0 - (ty_d << 2);
	assign dec_pos  = (dec_q != '0) && !dec_q[DW-1];

	always_ff @(posedge clk) begin
		if (cmd.ld_target) begin
			tx_q <= end_x;
			ty_q <= end_y;
		end
		if (mul_en) begin
			p_q <= prod;
		end
		if (cmd.ld_dx2) begin
			dx2_q <= p_q[TW-1:0];
		end
		if (cmd.ld_turn_x) begin
			turn_x_q <= quotient[TW-1:0];
		end
		if (cmd.ld_t2) begin
			t2_q <= p_q[QW-1:0];
		end
		if (cmd.ld_turn_y) begin
			turn_y_q <= quotient[TW-1:0];
		end
		if (cmd.ld_ew2) begin
			ew2_q <= p_d;
		end
		if (cmd.ld_sdec) begin
			sdec_q <= (p_d << 2) - ew2_q;
		end
		if (cmd.ld_smove) begin
			smove_q <= dx4 - (p_d << 3);
			ssame_q <= dx4;
		end
		if (cmd.init_flat) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			dec_q   <= t2_d - (ty_d << 1);
			same_q  <= '0 - ty6;
			move_q  <= (t2_d << 1) - ty6;
		end
		unique case (cmd.step_kind)
			STEP_IDLE: begin
				pixel_x_q <= '0;
				pixel_y_q <= '0;
				marker_q  <= 1'b0;
				last_q    <= 1'b0;
				status_q  <= 1'b1;
			end
			STEP_FLAT: begin
				pixel_x_q <= cur_x_q[PXW-1:0];
				pixel_y_q <= cur_y_q[PXW-1:0];
				marker_q  <= 1'b0;
				last_q    <= 1'b0;
				status_q  <= 1'b0;
				if (st.at_turn) begin
					cur_x_q <= turn_x_q;
					cur_y_q <= turn_y_q;
					dec_q   <= sdec_q;
					move_q  <= smove_q;
					same_q  <= ssame_q;
				end else begin
					cur_x_q <= cur_x_q + TW'(1);
					if (dec_pos) begin
						dec_q <= dec_q + same_q;
					end else begin
						dec_q   <= dec_q + move_q;
						cur_y_q <= cur_y_q + TW'(1);
					end
					same_q <= same_q + inc_flat;
					move_q <= move_q + inc_flat;
				end
			end
			STEP_STEEP: begin
				pixel_x_q <= cur_x_q[PXW-1:0];
				pixel_y_q <= cur_y_q[PXW-1:0];
				marker_q  <= 1'b0;
				last_q    <= 1'b0;
				status_q  <= 1'b0;
				if (dec_pos) begin
					dec_q   <= dec_q + move_q;
					move_q  <= move_q - ty8;
					cur_x_q <= cur_x_q + TW'(1);
				end else begin
					dec_q <= dec_q + same_q;
				end
				if (!st.cur_ge_ty) begin
					cur_y_q <= cur_y_q + TW'(1);
				end
			end
			STEP_MARK: begin
				pixel_x_q <= turn_x_q[PXW-1:0];
				pixel_y_q <= turn_y_q[PXW-1:0];
				marker_q  <= 1'b1;
				last_q    <= 1'b1;
				status_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign st.coord_zero = (end_x == '0) || (end_y == '0);
	assign st.at_turn    = cur_x_q == turn_x_q;
	assign st.turn_le_ty = turn_y_q <= TW'(ty_q);
	assign st.cur_ge_ty  = cur_y_q >= TW'(ty_q);
	assign st.div_done   = div_done;

	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign marker  = marker_q;
	assign last    = last_q;
	assign status  = status_q;

endmodule

@@ rtl/mpr_ctrl.sv @@
// Controller of the rasteriser: set-up sequence, drawing phases and result handshake.
module mpr_ctrl import mpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cmd_t       in_cmd,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       drawing;
	logic       accept;
	logic       start_go;
	logic       step_go;
	logic       emit;

	assign drawing  = (state_q == CS_IDLE) || (state_q == CS_FLAT) ||
		(state_q == CS_STEEP) || (state_q == CS_MARK);
	assign in_ready = drawing && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign start_go = accept && (in_cmd == CMD_START) && !st.coord_zero;
	assign step_go  = accept && (in_cmd == CMD_STEP);
	assign emit     = cmd.step_kind != STEP_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			CS_IDLE: begin
				if (step_go) begin
					cmd.step_kind = STEP_IDLE;
				end
			end
			CS_FLAT: begin
				if (step_go) begin
					cmd.step_kind = STEP_FLAT;
					if (st.at_turn) begin
						state_d = st.turn_le_ty ? CS_STEEP : CS_MARK;
					end
				end
			end
			CS_STEEP: begin
				if (step_go) begin
					cmd.step_kind = STEP_STEEP;
					if (st.cur_ge_ty) begin
						state_d = CS_MARK;
					end
				end
			end
			CS_MARK: begin
				if (step_go) begin
					cmd.step_kind = STEP_MARK;
					state_d       = CS_IDLE;
				end
			end
			CS_SQX: begin
				cmd.mul_op = MUL_SQX;
				state_d    = CS_DIV1;
			end
			CS_DIV1: begin
				cmd.ld_dx2 = 1'b1;
				cmd.div_op = DIV_TURN_X;
				state_d    = CS_DIV1W;
			end
			CS_DIV1W: begin
				if (st.div_done) begin
					cmd.ld_turn_x = 1'b1;
					state_d       = CS_SQT;
				end
			end
			CS_SQT: begin
				cmd.mul_op = MUL_SQT;
				state_d    = CS_TXY;
			end
			CS_TXY: begin
				cmd.ld_t2  = 1'b1;
				cmd.mul_op = MUL_TXY;
				state_d    = CS_NUM;
			end
			CS_NUM: begin
				cmd.mul_op = MUL_NUM;
				state_d    = CS_DIV2;
			end
			CS_DIV2: begin
				cmd.div_op = DIV_TURN_Y;
				state_d    = CS_DIV2W;
			end
			CS_DIV2W: begin
				if (st.div_done) begin
					cmd.ld_turn_y = 1'b1;
					state_d       = CS_W1;
				end
			end
			CS_W1: begin
				cmd.mul_op = MUL_W1;
				state_d    = CS_W2;
			end
			CS_W2: begin
				cmd.mul_op = MUL_W2;
				state_d    = CS_SD;
			end
			CS_SD: begin
				cmd.ld_ew2 = 1'b1;
				cmd.mul_op = MUL_SD;
				state_d    = CS_SD2;
			end
			CS_SD2: begin
				cmd.ld_sdec = 1'b1;
				cmd.mul_op  = MUL_SM;
				state_d     = CS_SM;
			end
			CS_SM: begin
				cmd.ld_smove  = 1'b1;
				cmd.init_flat = 1'b1;
				state_d       = CS_FLAT;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
		if (start_go) begin
			cmd.ld_target = 1'b1;
			state_d       = CS_SQX;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/midpoint_parabola_rasterizer.sv @@
// Top level of the midpoint parabola rasteriser.
// A start word (tuser low) loads the end point and works out the change point of the curve;
// it produces no result word and holds the input until the set-up is done, a time set by the
// one-bit-per-cycle divider, which runs twice, and the shared set-up multiplier. A start word
// with a zero coordinate is taken and ignored. Each step word (tuser high) then produces one
// pixel word, registered in the cycle after it is taken, so steps flow at one per cycle while
// the output is drained: first the flat region, then the steep region if the change point's y
// does not exceed the end point's, then a marker pixel at the change point, which also carries
// tlast. A step with no curve active returns a word with the status bit set and all else zero.
module midpoint_parabola_rasterizer import mpr_pkg::*; #(
	parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
	parameter int unsigned DECISION_BITS = DECISION_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// end_x, end_y, zero padding.
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata,
	// command.
	input  logic [0:0]                                    s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// pixel_x, pixel_y, zero padding.
	output logic [((2*(2*COORD_BITS-1)+7)/8)*8-1:0]       m_axis_tdata,
	// marker, status.
	output logic [1:0]                                    m_axis_tuser,
	output logic                                          m_axis_tlast
);

	localparam int unsigned CW      = COORD_BITS;
	localparam int unsigned PXW     = 2 * CW - 1;
	localparam int unsigned OUT_TDW = ((2 * PXW + 7) / 8) * 8;

	dp_cmd_t        dp_cmd;
	dp_status_t     dp_st;
	logic [PXW-1:0] pixel_x, pixel_y;
	logic           marker, last, status;

	mpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (cmd_t'(s_axis_tuser[0])),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (dp_st),
		.cmd       (dp_cmd)
	);

	mpr_datapath #(
		.COORD_BITS    (COORD_BITS),
		.DECISION_BITS (DECISION_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.end_x   (s_axis_tdata[CW-1:0]),
		.end_y   (s_axis_tdata[2*CW-1:CW]),
		.cmd     (dp_cmd),
		.st      (dp_st),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.marker  (marker),
		.last    (last),
		.status  (status)
	);

	assign m_axis_tdata = OUT_TDW'({pixel_y, pixel_x});
	assign m_axis_tuser = {status, marker};
	assign m_axis_tlast = last;

	a_step_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_STEP) |=> m_axis_tvalid)
		else $error("A step word was taken but no result word followed.");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[USER_MARKER]))
		else $error("The marker pixel and the last pixel disagree.");

	a_status_word_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_STATUS] |->
		!m_axis_tlast && !m_axis_tuser[USER_MARKER] && (m_axis_tdata == '0))
		else $error("A word without an active curve carries pixel data.");

	a_div_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dp_st.div_done |-> !s_axis_tready)
		else $error("The divider finished while the input was open.");

endmodule
